// File: hw/rtl/blrg_pkg.sv
// ----------------------------------------------------------------------------
// blrg_pkg
// Shared types and constants for the biquad low-pass, rectifier and gate.
// ----------------------------------------------------------------------------
package blrg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 20;
    localparam int THRESH_W = 15;
    localparam int RECT_W   = 15;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int ACC_W    = PROD_W + 4;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 32;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // Register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_THRESH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    typedef struct packed {
        t_sample           filtered;
        logic [RECT_W-1:0] rectified;
    } t_filt_res;

    typedef struct packed {
        logic frame_end;
        logic gate_open;
    } t_gate_res;

endpackage

// File: hw/rtl/biquad_lowpass_rectify_gate_core.sv
// ----------------------------------------------------------------------------
// biquad_lowpass_rectify_gate_core
// Biquad low-pass with half-wave rectifier and frame magnitude gate.
// ----------------------------------------------------------------------------
// One signed 16-bit sample per word enters on the slave stream, tlast closing
// a frame. Each sample gives exactly one result word: the biquad output
// (b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2, rounded half up, scaled down by
// 2^COEF_FRAC_BITS and clipped to 16 bits), its half-wave rectified value,
// and on the word that closes a frame (tlast, or the MAX_FRAME-th sample) a
// gate flag that is set when the sum of |x| over the frame reaches
// threshold * sample count. The delay line runs on across frames. The block
// takes one word per clock cycle while the result stream is not stalled; a
// word passes through the input register and the result register. The
// cycle time is set by the filter feedback loop: five 20x16 products, their
// sum, rounding and clipping into the output delay register. Configuration
// writes land at once and must be made while no sample is in flight.
// ----------------------------------------------------------------------------
module biquad_lowpass_rectify_gate_core import blrg_pkg::*; #(
    parameter int MAX_FRAME      = 4096,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Sample stream in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_DATA_W-1:0]  s_axis_tdata,   // [15:0] sample_in
    input  logic                 s_axis_tlast,   // last_in_frame
    // Result stream out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_DATA_W-1:0]  m_axis_tdata,   // [15:0] filtered_sample,
                                                 // [30:16] rectified_sample,
                                                 // [31] gate_open
    output logic                 m_axis_tlast    // frame_end
);

    // Configuration registers
    t_coefs              r_coefs;
    logic [THRESH_W-1:0] r_thresh;

    // Input register
    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_in_last;

    // Result register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_last;

    logic      adv;
    logic      fire;
    t_filt_res filt;
    t_gate_res gate;

    // Decode register writes; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs  <= '0;
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_B0:     r_coefs.b0 <= i_cfg_data[COEF_W-1:0];
                REG_B1:     r_coefs.b1 <= i_cfg_data[COEF_W-1:0];
                REG_B2:     r_coefs.b2 <= i_cfg_data[COEF_W-1:0];
                REG_A1:     r_coefs.a1 <= i_cfg_data[COEF_W-1:0];
                REG_A2:     r_coefs.a2 <= i_cfg_data[COEF_W-1:0];
                REG_THRESH: r_thresh   <= i_cfg_data[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The result register frees whenever it is empty or being drained;
    // the held sample then moves through the datapath into it.
    assign adv           = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && adv;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Capture the payload only on a handshake; hold it otherwise
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_in_last   <= s_axis_tlast;
        end
    end

    blrg_biquad #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_biquad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (fire),
        .i_sample (r_in_sample),
        .i_coefs  (r_coefs),
        .o_res    (filt)
    );

    blrg_gate #(
        .MAX_FRAME (MAX_FRAME)
    ) u_gate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (fire),
        .i_sample (r_in_sample),
        .i_last   (r_in_last),
        .i_thresh (r_thresh),
        .o_res    (gate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {gate.gate_open, filt.rectified, filt.filtered};
            r_out_last <= gate.frame_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    a_gate_only_at_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[M_DATA_W-1] |-> m_axis_tlast)
        else $error("gate flag set on a word that does not close a frame");

    a_rect_matches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[SAMPLE_W+RECT_W-1:SAMPLE_W] ==
            (m_axis_tdata[SAMPLE_W-1] ? RECT_W'(0) : m_axis_tdata[RECT_W-1:0]))
        else $error("rectified value disagrees with filtered value");

    a_fire_fills_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed sample did not reach the result register");

endmodule

// File: hw/rtl/blrg_biquad.sv
// ----------------------------------------------------------------------------
// blrg_biquad
// Direct-form-I biquad with round half up, saturation and half-wave rectifier.
// ----------------------------------------------------------------------------
module blrg_biquad import blrg_pkg::*; #(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_sample   i_sample,
    input  t_coefs    i_coefs,
    output t_filt_res o_res
);

    localparam logic signed [ACC_W-1:0] ROUND_K = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

    t_sample r_x1, r_x2, r_y1, r_y2;

    logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]  acc, shf;
    t_sample                  y;

    assign p0 = i_coefs.b0 * i_sample;
    assign p1 = i_coefs.b1 * r_x1;
    assign p2 = i_coefs.b2 * r_x2;
    assign p3 = i_coefs.a1 * r_y1;
    assign p4 = i_coefs.a2 * r_y2;

    assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4) + ROUND_K;
    assign shf = acc >>> COEF_FRAC_BITS;

    always_comb begin
        if (shf > SAT_MAX) begin
            y = SAT_MAX[SAMPLE_W-1:0];
        end else if (shf < SAT_MIN) begin
            y = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            y = shf[SAMPLE_W-1:0];
        end
    end

    assign o_res.filtered  = y;
    assign o_res.rectified = y[SAMPLE_W-1] ? '0 : y[RECT_W-1:0];

    // Advance the delay line with the clipped output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_en) begin
            r_x2 <= r_x1;
            r_x1 <= i_sample;
            r_y2 <= r_y1;
            r_y1 <= y;
        end
    end

endmodule

// File: hw/rtl/blrg_gate.sv
// ----------------------------------------------------------------------------
// blrg_gate
// Per-frame magnitude sum and mean-versus-threshold gate decision.
// ----------------------------------------------------------------------------
module blrg_gate import blrg_pkg::*; #(
    parameter int MAX_FRAME = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_sample             i_sample,
    input  logic                i_last,
    input  logic [THRESH_W-1:0] i_thresh,
    output t_gate_res           o_res
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam int SUM_W = CNT_W + THRESH_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    bar;
    logic                closes;

    // Magnitude of the most negative sample wraps to 0x8000, read unsigned
    assign mag    = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : i_sample;
    assign n_sum  = r_sum + SUM_W'(mag);
    assign n_cnt  = r_cnt + CNT_W'(1);
    assign closes = i_last || (n_cnt == CNT_MAX);
    assign bar    = SUM_W'(i_thresh) * SUM_W'(n_cnt);

    assign o_res.frame_end = closes;
    assign o_res.gate_open = closes && (n_sum >= bar);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_en) begin
            r_sum <= closes ? '0 : n_sum;
            r_cnt <= closes ? '0 : n_cnt;
        end
    end

    a_cnt_below_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_MAX)
        else $error("frame count reached the frame limit without closing");

    a_close_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && closes |=> r_cnt == '0 && r_sum == '0)
        else $error("frame accumulator not cleared at frame end");

endmodule

// File: tb/tb_biquad_lowpass_rectify_gate_core.sv
// ----------------------------------------------------------------------------
// tb_biquad_lowpass_rectify_gate_core
// Self-checking bench for the biquad low-pass, rectifier and frame gate.
// ----------------------------------------------------------------------------
// A directed table opens the run: reset state, unity and half gain, the gate
// threshold boundary, register bits above width, unused register indexes and
// extreme coefficients. Random phases follow, each with its own coefficient
// set and threshold, sending frames of random length and amplitude, some with
// a misplaced frame mark. Every result word is checked against a behavioural
// model of the filter and the gate, or against the result typed into a row.
// ----------------------------------------------------------------------------
module tb_biquad_lowpass_rectify_gate_core;
    timeunit 1ns;
    timeprecision 1ps;

    import blrg_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_FRAME      = 4096;
    localparam int COEF_FRAC_BITS = 16;
    localparam int PIPE_LATENCY   = 2;      // input register plus result register
    localparam int SETTLE_CYCLES  = 8;
    localparam int STALL_LIMIT    = 2000;   // cycles with no word and no write
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_WORDS    = 115;
    localparam int SUM_W          = 28;
    localparam int COUNT_W        = 13;

    // Indexes outside the register map; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam t_coef COEF_MAX  = 20'sh7FFFF;
    localparam t_coef COEF_MIN  = 20'sh80000;
    localparam t_coef COEF_UNIT = 20'sh10000;   // 1.0 in Q3.16
    localparam t_coef COEF_HALF = 20'sh08000;   // 0.5 in Q3.16

    // One result word, unpacked from the output stream
    typedef struct packed {
        t_sample           filtered;
        logic [RECT_W-1:0] rectified;
        logic              frame_end;
        logic              gate_open;
    } t_bq_word;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    // One row of the directed table: a register write or a sample word
    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        t_sample              x;
        logic                 last;
        logic                 known;    // result typed into the row
        t_bq_word             res;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;   // [15:0] sample_in
    logic                  s_axis_tlast  = 1'b0; // last_in_frame
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;         // [15:0] filtered_sample,
                                                 // [30:16] rectified_sample,
                                                 // [31] gate_open
    logic                  m_axis_tlast;         // frame_end

    biquad_lowpass_rectify_gate_core #(
        .MAX_FRAME      (MAX_FRAME),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter and gate model: own copy of the registers and the state
    // ------------------------------------------------------------------------
    t_coefs                coef_q    = '0;
    logic [THRESH_W-1:0]   thresh_q  = '0;
    t_sample               x_d1      = '0;
    t_sample               x_d2      = '0;
    t_sample               y_d1      = '0;
    t_sample               y_d2      = '0;
    logic [SUM_W-1:0]      mag_sum   = '0;
    logic [COUNT_W-1:0]    run_len   = '0;

    t_bq_word              expected_q[$];
    t_stim_row             dir_rows[$];
    int                    fail_count = 0;
    int                    burst_left = 0;
    int                    idle_cycles = 0;

    // Advance the model by one sample and return the word it should produce
    function automatic t_bq_word filter_word(t_sample x, logic last);
        longint               acc;
        longint               y;
        longint               mag;
        logic [COUNT_W-1:0]   n;
        logic                 closes;
        t_bq_word             w;
        acc = longint'($signed(coef_q.b0)) * longint'(x)
            + longint'($signed(coef_q.b1)) * longint'(x_d1)
            + longint'($signed(coef_q.b2)) * longint'(x_d2)
            - longint'($signed(coef_q.a1)) * longint'(y_d1)
            - longint'($signed(coef_q.a2)) * longint'(y_d2);
        // Round half up, then floor through the arithmetic shift
        acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        y   = acc >>> COEF_FRAC_BITS;
        if (y > 32767) begin
            y = 32767;
        end
        if (y < -32768) begin
            y = -32768;
        end
        // The clipped value is what goes into the feedback delay line
        x_d2 = x_d1;
        x_d1 = x;
        y_d2 = y_d1;
        y_d1 = t_sample'(y);
        // -32768 counts as a magnitude of 32768
        mag     = (x < 0) ? -longint'(x) : longint'(x);
        mag_sum = mag_sum + SUM_W'(mag);
        n       = run_len + 1'b1;
        closes  = last || (int'(n) >= MAX_FRAME);
        w.gate_open = 1'b0;
        if (closes) begin
            w.gate_open = longint'(mag_sum) >= longint'(thresh_q) * longint'(n);
            mag_sum = '0;
            run_len = '0;
        end else begin
            run_len = n;
        end
        w.filtered  = t_sample'(y);
        w.rectified = (y > 0) ? RECT_W'(y) : '0;
        w.frame_end = closes;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------
    function automatic void add_row(t_stim_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // Sample row left to the model
    function automatic t_stim_row sample_row(t_sample x, logic last);
        t_stim_row r;
        r      = '0;
        r.kind = ROW_SAMPLE;
        r.x    = x;
        r.last = last;
        return r;
    endfunction

    // Sample row whose result can be read straight off the setting
    function automatic t_stim_row known_row(t_sample x, logic last, t_sample y,
                                            logic [RECT_W-1:0] rect, logic fe, logic gate);
        t_stim_row r;
        r                 = sample_row(x, last);
        r.known           = 1'b1;
        r.res.filtered    = y;
        r.res.rectified   = rect;
        r.res.frame_end   = fe;
        r.res.gate_open   = gate;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side: bursts of random length, random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_sample(t_sample x, logic last, logic known, t_bq_word typed);
        int           gap;
        t_bq_word     predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // Word taken: the model always advances, a typed row overrides its answer
        predicted = filter_word(x, last);
        expected_q.insert(expected_q.size(), known ? typed : predicted);
    endtask

    // Hold the sender until every outstanding word is out, then let the
    // pipeline settle so register writes land on an idle block
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Leave the write enable high; cfg_close drops it after the last write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (t_reg_idx'(idx))
            REG_B0:     coef_q.b0 = t_coef'(data);
            REG_B1:     coef_q.b1 = t_coef'(data);
            REG_B2:     coef_q.b2 = t_coef'(data);
            REG_A1:     coef_q.a1 = t_coef'(data);
            REG_A2:     coef_q.a2 = t_coef'(data);
            REG_THRESH: thresh_q  = data[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_config(t_coefs c, logic [CFG_W-1:0] thr);
        drain_results();
        cfg_write(REG_B0, c.b0);
        cfg_write(REG_B1, c.b1);
        cfg_write(REG_B2, c.b2);
        cfg_write(REG_A1, c.a1);
        cfg_write(REG_A2, c.a2);
        cfg_write(REG_THRESH, thr);
        cfg_close();
    endtask

    // Pick one coefficient from the corners or at random
    function automatic t_coef corner_coef();
        case ($urandom_range(0, 3))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            default: return t_coef'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver side: ready follows a rotating 32-bit pattern, reloaded each time
    // it has rotated through with always-ready, noise, mostly-ready or one long stall
    // ------------------------------------------------------------------------
    logic [31:0] stall_bits = '1;
    int          stall_age  = 0;

    always @(posedge i_clk) begin : rx_pace
        logic [31:0] bits;
        bits = stall_bits;
        if (stall_age == 0) begin
            case ($urandom_range(0, 3))
                0:       bits = '1;
                1:       bits = $urandom;
                2:       bits = $urandom | $urandom;
                default: bits = 32'hFFFF_0000;
            endcase
        end
        m_axis_tready <= bits[0];
        stall_bits    <= {bits[0], bits[31:1]};
        stall_age     <= (stall_age == 31) ? 0 : stall_age + 1;
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_bq_word got;
        t_bq_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.filtered  = m_axis_tdata[SAMPLE_W-1:0];
            got.rectified = m_axis_tdata[SAMPLE_W+RECT_W-1:SAMPLE_W];
            got.gate_open = m_axis_tdata[M_DATA_W-1];
            got.frame_end = m_axis_tlast;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected word: y=%0d rect=%0d end=%0b gate=%0b",
                             got.filtered, got.rectified, got.frame_end, got.gate_open);
                end
            end else begin
                want = expected_q.pop_front();
                if (got.filtered !== want.filtered || got.rectified !== want.rectified ||
                    got.frame_end !== want.frame_end || got.gate_open !== want.gate_open) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: want y=%0d rect=%0d end=%0b gate=%0b",
                                 want.filtered, want.rectified, want.frame_end,
                                 want.gate_open);
                        $display("          got  y=%0d rect=%0d end=%0b gate=%0b",
                                 got.filtered, got.rectified, got.frame_end,
                                 got.gate_open);
                    end
                end
            end
        end
    end

    // Watchdog: give up when neither stream nor the write port moves
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_biquad_lowpass_rectify_gate_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_coefs              c;
        logic [CFG_W-1:0]    thr;
        t_sample             x;
        logic                last;
        int                  words;
        int                  len;
        int                  shift;

        // Straight after reset all coefficients are zero and the threshold is
        // zero, so the output is silent and the gate opens on every frame
        add_row(known_row(16'sh7FFF, 1'b0, '0, '0, 1'b0, 1'b0));
        add_row(known_row(16'sh8000, 1'b0, '0, '0, 1'b0, 1'b0));
        add_row(known_row(-16'sd1,   1'b1, '0, '0, 1'b1, 1'b1));

        // Unity gain; threshold write carries junk above its width (gives 100);
        // writes to the unused indexes follow and must not disturb b0
        add_row(cfg_row(REG_B0, COEF_UNIT));
        add_row(cfg_row(REG_B1, '0));
        add_row(cfg_row(REG_B2, '0));
        add_row(cfg_row(REG_A1, '0));
        add_row(cfg_row(REG_A2, '0));
        add_row(cfg_row(REG_THRESH, 20'hF8064));
        add_row(cfg_row(REG_SPARE_6, 20'hFFFFF));
        add_row(cfg_row(REG_SPARE_7, 20'h5A5A5));
        add_row(known_row(16'sh7FFF, 1'b0, 16'sh7FFF, 15'h7FFF, 1'b0, 1'b0));
        add_row(known_row(16'sh8000, 1'b0, 16'sh8000, '0, 1'b0, 1'b0));
        add_row(known_row(16'sd0,    1'b0, 16'sd0, '0, 1'b0, 1'b0));
        add_row(known_row(16'sd1,    1'b1, 16'sd1, 15'd1, 1'b1, 1'b1));
        // Single quiet sample: 5 < 100, gate stays shut
        add_row(known_row(16'sd5,    1'b1, 16'sd5, 15'd5, 1'b1, 1'b0));
        // Sum one below threshold * count, then exactly on it
        add_row(known_row(16'sd99,   1'b0, 16'sd99, 15'd99, 1'b0, 1'b0));
        add_row(known_row(-16'sd100, 1'b1, -16'sd100, '0, 1'b1, 1'b0));
        add_row(known_row(16'sd100,  1'b0, 16'sd100, 15'd100, 1'b0, 1'b0));
        add_row(known_row(-16'sd100, 1'b1, -16'sd100, '0, 1'b1, 1'b1));

        // Half gain shows the rounding: +0.5 goes up, -0.5 goes to zero,
        // -1.5 goes up to -1
        add_row(cfg_row(REG_B0, COEF_HALF));
        add_row(known_row(16'sd1,    1'b0, 16'sd1, 15'd1, 1'b0, 1'b0));
        add_row(known_row(-16'sd1,   1'b0, 16'sd0, '0, 1'b0, 1'b0));
        add_row(known_row(-16'sd3,   1'b1, -16'sd1, '0, 1'b1, 1'b0));

        // Extreme coefficients drive the accumulator into both clip limits;
        // top threshold written with every upper bit set
        add_row(cfg_row(REG_B0, COEF_MAX));
        add_row(cfg_row(REG_B1, COEF_MAX));
        add_row(cfg_row(REG_B2, COEF_MAX));
        add_row(cfg_row(REG_A1, COEF_MIN));
        add_row(cfg_row(REG_A2, COEF_MAX));
        add_row(cfg_row(REG_THRESH, 20'hFFFFF));
        add_row(sample_row(16'sh7FFF, 1'b0));
        add_row(sample_row(16'sh7FFF, 1'b0));
        add_row(sample_row(16'sh8000, 1'b0));
        add_row(sample_row(16'sh8000, 1'b0));
        add_row(sample_row(16'sh7FFF, 1'b1));

        // All coefficients at the negative limit; threshold bit above width only
        add_row(cfg_row(REG_B0, COEF_MIN));
        add_row(cfg_row(REG_B1, COEF_MIN));
        add_row(cfg_row(REG_B2, COEF_MIN));
        add_row(cfg_row(REG_A1, COEF_MIN));
        add_row(cfg_row(REG_A2, COEF_MIN));
        add_row(cfg_row(REG_THRESH, 20'h08000));
        add_row(sample_row(16'sh8000, 1'b0));
        add_row(sample_row(16'sh7FFF, 1'b0));
        add_row(sample_row(-16'sd1,   1'b0));
        add_row(sample_row(16'sh8000, 1'b1));

        // Hold reset, release it on an edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                drain_results();
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
                cfg_close();
            end else begin
                send_sample(dir_rows[r].x, dir_rows[r].last, dir_rows[r].known,
                            dir_rows[r].res);
            end
        end

        // Random phases: rotate through a plausible low-pass, fully random
        // coefficients and coefficients drawn from the corners
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 3)
                0: begin
                    c.b0 = t_coef'($urandom_range(200, 6000));
                    c.b1 = c.b0 <<< 1;
                    c.b2 = c.b0;
                    c.a1 = t_coef'(-int'($urandom_range(60000, 125000)));
                    c.a2 = t_coef'($urandom_range(25000, 62000));
                end
                1: begin
                    c.b0 = t_coef'($urandom);
                    c.b1 = t_coef'($urandom);
                    c.b2 = t_coef'($urandom);
                    c.a1 = t_coef'($urandom);
                    c.a2 = t_coef'($urandom);
                end
                default: begin
                    c.b0 = corner_coef();
                    c.b1 = corner_coef();
                    c.b2 = corner_coef();
                    c.a1 = corner_coef();
                    c.a2 = corner_coef();
                end
            endcase
            // Spread thresholds over the range of frame amplitudes; junk on top
            thr = {5'($urandom), 15'($urandom_range(0, 32767) >> $urandom_range(0, 15))};
            load_config(c, thr);

            words = 0;
            while (words < PHASE_WORDS) begin
                // One frame with its own amplitude; now and then a stray mark
                len   = $urandom_range(1, 24);
                shift = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                for (int k = 0; k < len; k++) begin
                    x    = t_sample'($urandom) >>> shift;
                    last = (k == len - 1);
                    if ($urandom_range(0, 15) == 0) begin
                        last = 1'($urandom_range(0, 1));
                    end
                    send_sample(x, last, 1'b0, '0);
                    words++;
                    // Occasionally hold until the output has caught up
                    if ($urandom_range(0, 199) == 0) begin
                        drain_results();
                    end
                end
            end
        end

        // Drain, let the pipeline settle, then report
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("tb_biquad_lowpass_rectify_gate_core: PASS");
        end else begin
            $display("tb_biquad_lowpass_rectify_gate_core: FAIL");
        end
        $finish;
    end

endmodule
